[src/zrlv_pkg.sv]
// Package for the ZYZ rotation and link vector block.
// Holds the quarter-wave sine table, lookup and saturation helpers, and shared types.
// Used by every module of the block; depends on nothing else.
package zrlv_pkg;

    localparam int JointCountDef = 4;
    localparam int QwSize        = 257;
    localparam int InDataW       = 56;
    localparam int OutDataW      = 192;

    localparam logic ReqLoad    = 1'b0;
    localparam logic ReqCompute = 1'b1;

    typedef logic [14:0] qwave_t [QwSize];

    typedef struct packed {
        logic [14:0] lo;
        logic [14:0] hi;
        logic [5:0]  frac;
        logic        neg;
    } qlook_t;

    // Q30 Taylor series of sin up to x^11, rounded to unsigned Q0.15
    function automatic qwave_t build_qwave();
        qwave_t          tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        for (int k = 0; k < QwSize; k++) begin
            x  = (longint'(k) * 64'd1686629713 + 64'd128) >> 8;
            x2 = (x * x) >> 30;
            t  = (64'd1 << 30) - x2 / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tbl[k] = q[14:0];
        end
        return tbl;
    endfunction

    localparam qwave_t QWAVE = build_qwave();

    // Fold an angle into the quarter wave and fetch both interpolation points
    function automatic qlook_t qlook(input logic [15:0] a);
        qlook_t      res;
        logic [14:0] u;
        logic [8:0]  idx;
        logic [8:0]  idx_hi;
        u      = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        idx    = u[14:6];
        idx_hi = (idx == 9'd256) ? idx : idx + 9'd1;
        res.lo   = QWAVE[idx];
        res.hi   = QWAVE[idx_hi];
        res.frac = u[5:0];
        res.neg  = a[15];
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        if (v > 50'sd32767) begin
            return 16'sh7fff;
        end else if (v < -50'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

[src/zrlv_trig_mem.sv]
// Per-joint table of sin/cos alpha and beta, one 4x16-bit row per joint.
// Slot write on load, registered row read whenever rd_en is set. Uses zrlv_pkg.
module zrlv_trig_mem #(
    parameter int JOINT_COUNT = zrlv_pkg::JointCountDef
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic                             rd_en,
    input  logic [$clog2(JOINT_COUNT+1)-1:0] addr,
    input  logic [1:0]                       slot,
    input  logic signed [15:0]               wr_data,
    output logic [3:0][15:0]                 rd_data
);
    import zrlv_pkg::*;

    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    logic [3:0][15:0] mem [JOINT_COUNT];
    logic [3:0][15:0] rd_data_reg;
    logic [AW-1:0]    row;

    assign row = addr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[row][slot] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/zrlv_sincos.sv]
// Sine and cosine of the joint angle from the quarter-wave table.
// Two stages: table fetch, then linear interpolation and sign. Uses zrlv_pkg.
module zrlv_sincos (
    input  logic               aclk,
    input  logic               adv,
    input  logic [15:0]        angle,
    output logic signed [15:0] sin_t,
    output logic signed [15:0] cos_t
);
    import zrlv_pkg::*;

    qlook_t             s_look_reg;
    qlook_t             c_look_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_next;
    logic signed [15:0] cos_next;

    function automatic logic signed [15:0] interp(input qlook_t l);
        logic [20:0] prod;
        logic [15:0] mag;
        prod = 21'(l.hi - l.lo) * 21'(l.frac) + 21'd32;
        mag  = {1'b0, l.lo} + {1'b0, prod[20:6]};
        return l.neg ? -$signed(mag) : $signed(mag);
    endfunction

    always_comb begin
        sin_next = interp(s_look_reg);
        cos_next = interp(c_look_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_look_reg <= qlook(angle);
            c_look_reg <= qlook(angle + 16'd16384);
            sin_reg    <= sin_next;
            cos_reg    <= cos_next;
        end
    end

    assign sin_t = sin_reg;
    assign cos_t = cos_reg;

endmodule

[src/zrlv_rot_pipe.sv]
// Rotation matrix and link vector datapath: pair products, triple products,
// rounded sums, then length scaling. Five register stages. Uses zrlv_pkg.
module zrlv_rot_pipe (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [3:0][15:0]              trig,
    input  logic signed [15:0]            len_in,
    input  logic signed [15:0]            sin_t,
    input  logic signed [15:0]            cos_t,
    output logic [zrlv_pkg::OutDataW-1:0] result
);
    import zrlv_pkg::*;

    // stage: capture table row and length in step with sin/cos
    logic signed [15:0] sa_reg, ca_reg, sb_reg, cb_reg, len2_reg;
    // pair products
    logic signed [31:0] p_cacb_reg, p_cbsa_reg, p_sast_reg, p_sact_reg, p_cast_reg;
    logic signed [31:0] p_cact_reg, p_casb_reg, p_sasb_reg, p_sbct_reg, p_sbst_reg;
    logic signed [15:0] st3_reg, ct3_reg, cb3_reg, len3_reg;
    // triple products
    logic signed [47:0] t_cacbct_reg, t_cacbst_reg, t_cbsact_reg, t_cbsast_reg;
    logic signed [31:0] p_sast4_reg, p_sact4_reg, p_cast4_reg, p_cact4_reg;
    logic signed [31:0] p_casb4_reg, p_sasb4_reg, p_sbct4_reg, p_sbst4_reg;
    logic signed [15:0] cb4_reg, len4_reg;
    // matrix
    logic signed [15:0] rot_reg [9];
    logic signed [15:0] rot_next [9];
    logic signed [15:0] len5_reg;
    // output word
    logic [OutDataW-1:0] out_reg;
    logic [OutDataW-1:0] out_next;

    function automatic logic signed [15:0] rs30(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = v + (50'sd1 <<< 29);
        return sat16(t >>> 30);
    endfunction

    function automatic logic signed [15:0] rs15(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = v + (50'sd1 <<< 14);
        return sat16(t >>> 15);
    endfunction

    always_comb begin
        rot_next[0] = rs30(50'(t_cacbct_reg) - (50'(p_sast4_reg) <<< 15));
        rot_next[1] = rs30(-(50'(p_sact4_reg) <<< 15) - 50'(t_cacbst_reg));
        rot_next[2] = rs15(50'(p_casb4_reg));
        rot_next[3] = rs30((50'(p_cast4_reg) <<< 15) + 50'(t_cbsact_reg));
        rot_next[4] = rs30((50'(p_cact4_reg) <<< 15) - 50'(t_cbsast_reg));
        rot_next[5] = rs15(50'(p_sasb4_reg));
        rot_next[6] = rs15(-50'(p_sbct4_reg));
        rot_next[7] = rs15(50'(p_sbst4_reg));
        rot_next[8] = cb4_reg;
        for (int k = 0; k < 9; k++) begin
            out_next[16*k +: 16] = rot_reg[k];
        end
        out_next[16*9 +: 16]  = rs15(50'(len5_reg) * 50'(rot_reg[0]));
        out_next[16*10 +: 16] = rs15(50'(len5_reg) * 50'(rot_reg[3]));
        out_next[16*11 +: 16] = rs15(50'(len5_reg) * 50'(rot_reg[6]));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg   <= trig[0];
            ca_reg   <= trig[1];
            sb_reg   <= trig[2];
            cb_reg   <= trig[3];
            len2_reg <= len_in;

            p_cacb_reg <= ca_reg * cb_reg;
            p_cbsa_reg <= cb_reg * sa_reg;
            p_sast_reg <= sa_reg * sin_t;
            p_sact_reg <= sa_reg * cos_t;
            p_cast_reg <= ca_reg * sin_t;
            p_cact_reg <= ca_reg * cos_t;
            p_casb_reg <= ca_reg * sb_reg;
            p_sasb_reg <= sa_reg * sb_reg;
            p_sbct_reg <= sb_reg * cos_t;
            p_sbst_reg <= sb_reg * sin_t;
            st3_reg    <= sin_t;
            ct3_reg    <= cos_t;
            cb3_reg    <= cb_reg;
            len3_reg   <= len2_reg;

            t_cacbct_reg <= 48'(p_cacb_reg) * 48'(ct3_reg);
            t_cacbst_reg <= 48'(p_cacb_reg) * 48'(st3_reg);
            t_cbsact_reg <= 48'(p_cbsa_reg) * 48'(ct3_reg);
            t_cbsast_reg <= 48'(p_cbsa_reg) * 48'(st3_reg);
            p_sast4_reg  <= p_sast_reg;
            p_sact4_reg  <= p_sact_reg;
            p_cast4_reg  <= p_cast_reg;
            p_cact4_reg  <= p_cact_reg;
            p_casb4_reg  <= p_casb_reg;
            p_sasb4_reg  <= p_sasb_reg;
            p_sbct4_reg  <= p_sbct_reg;
            p_sbst4_reg  <= p_sbst_reg;
            cb4_reg      <= cb3_reg;
            len4_reg     <= len3_reg;

            rot_reg  <= rot_next;
            len5_reg <= len4_reg;

            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

[src/zyz_rotation_and_link_vector.sv]
// ZYZ rotation matrix and link vector, top level with the stream handshake.
// Instantiates zrlv_trig_mem, zrlv_sincos and zrlv_rot_pipe; uses zrlv_pkg.
//
// One word is accepted per cycle while the output does not stall. A compute
// word's result appears on m_tdata after passing through the
// six register stages (table read, interpolation, pair products, triple products,
// rounding, length scaling). Load
// words write one slot of the joint table in the cycle they are accepted and
// give no result. The whole pipeline holds while the output word waits, so
// s_tready follows m_tready whenever the output register is full.
module zyz_rotation_and_link_vector #(
    parameter int JOINT_COUNT = zrlv_pkg::JointCountDef
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // joint[1:0], slot[3:2], table_value[19:4], angle[35:20], link_length[51:36]
    input  logic [zrlv_pkg::InDataW-1:0]   s_tdata,
    // req_type[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rot_00..rot_22 [143:0], pos_x[159:144], pos_y[175:160], pos_z[191:176]
    output logic [zrlv_pkg::OutDataW-1:0]  m_tdata
);
    import zrlv_pkg::*;

    localparam int AW = $clog2(JOINT_COUNT + 1);
    localparam int NStage = 6;

    logic        adv;
    logic        accept;
    logic [1:0]  joint;
    logic [1:0]  slot;
    logic [15:0] tvalue;
    logic [15:0] angle;
    logic [15:0] len;
    logic        joint_ok;
    logic        is_cmp;
    logic [AW-1:0] addr;

    logic [NStage-1:0] valid_reg;
    logic [NStage-1:0] valid_next;
    logic signed [15:0] len1_reg;

    logic [3:0][15:0]   trig;
    logic signed [15:0] sin_t;
    logic signed [15:0] cos_t;

    assign joint  = s_tdata[1:0];
    assign slot   = s_tdata[3:2];
    assign tvalue = s_tdata[19:4];
    assign angle  = s_tdata[35:20];
    assign len    = s_tdata[51:36];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign joint_ok = 32'(joint) < JOINT_COUNT;
    assign is_cmp   = (s_tuser == ReqCompute);
    assign addr     = AW'(joint);

    always_comb begin
        valid_next = {valid_reg[NStage-2:0], accept && is_cmp && joint_ok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len1_reg <= len;
        end
    end

    zrlv_trig_mem #(.JOINT_COUNT(JOINT_COUNT)) u_mem (
        .aclk    (aclk),
        .wr_en   (accept && (s_tuser == ReqLoad) && joint_ok),
        .rd_en   (adv),
        .addr    (addr),
        .slot    (slot),
        .wr_data (tvalue),
        .rd_data (trig)
    );

    zrlv_sincos u_sincos (
        .aclk  (aclk),
        .adv   (adv),
        .angle (angle),
        .sin_t (sin_t),
        .cos_t (cos_t)
    );

    zrlv_rot_pipe u_rot (
        .aclk   (aclk),
        .adv    (adv),
        .trig   (trig),
        .len_in (len1_reg),
        .sin_t  (sin_t),
        .cos_t  (cos_t),
        .result (m_tdata)
    );

    assign m_tvalid = valid_reg[NStage-1];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == ReqLoad) |=> !valid_reg[0])
        else $error("load word entered compute pipeline");

    a_pipe_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NStage-2] && adv) |=> m_tvalid)
        else $error("result lost before output register");

endmodule

[tb/tb.sv]
// Testbench for zyz_rotation_and_link_vector: drives load and compute words,
// predicts the rotation matrix and link vector in a scoreboard class and checks each result.
// Depends on zrlv_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
    import zrlv_pkg::*;

    localparam int NJoint = 4;

    typedef struct packed {
        logic signed [15:0] pz, py, px, r22, r21, r20, r12, r11, r10, r02, r01, r00;
    } rot_word_t;

    int mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    class kinematics_board;
        int  sine_wave [257];
        int  trig_row [NJoint*4];
        rot_word_t pending_q [$];

        function void build_wave();
            longint unsigned x, x2, t, s, q;
            for (int k = 0; k < 257; k++) begin
                x  = (longint'(k) * 64'd1686629713 + 64'd128) >> 8;
                x2 = (x * x) >> 30;
                t  = (64'd1 << 30) - x2 / 110;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
                t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
                s  = (x * t) >> 30;
                q  = (s + 16384) >> 15;
                if (q > 32767) q = 32767;
                sine_wave[k] = int'(q);
            end
        endfunction

        function int quarter_sin(int u);
            int i, f;
            if (u >= 16384) return sine_wave[256];
            i = u >> 6;
            f = u & 63;
            return sine_wave[i] + (((sine_wave[i+1] - sine_wave[i]) * f + 32) >>> 6);
        endfunction

        function longint angle_sin(int a);
            int r;
            r = a & 16'h3fff;
            case ((a >> 14) & 3)
                0: return quarter_sin(r);
                1: return quarter_sin(16384 - r);
                2: return -quarter_sin(r);
                default: return -quarter_sin(16384 - r);
            endcase
        endfunction

        // arithmetic shift floors, so adding half first rounds half up
        function logic signed [15:0] round_sat(longint v, int sh);
            longint r;
            r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
            if (r > 32767) return 16'sh7fff;
            if (r < -32768) return 16'sh8000;
            return r[15:0];
        endfunction

        function void note_word(logic req, logic [55:0] d);
            int j, sl;
            longint sa, ca, sb, cb, st, ct, len;
            rot_word_t w;
            j  = d[1:0];
            sl = d[3:2];
            if (j >= NJoint) return;
            if (req == ReqLoad) begin
                trig_row[j*4+sl] = $signed(d[19:4]);
                return;
            end
            sa = trig_row[j*4]; ca = trig_row[j*4+1];
            sb = trig_row[j*4+2]; cb = trig_row[j*4+3];
            st = angle_sin(d[35:20]);
            ct = angle_sin((d[35:20] + 16384) & 16'hffff);
            len = longint'($signed(d[51:36]));
            w.r00 = round_sat(ca*cb*ct - sa*st*32768, 30);
            w.r01 = round_sat(-sa*ct*32768 - ca*cb*st, 30);
            w.r02 = round_sat(ca*sb, 15);
            w.r10 = round_sat(ca*st*32768 + cb*sa*ct, 30);
            w.r11 = round_sat(ca*ct*32768 - cb*sa*st, 30);
            w.r12 = round_sat(sa*sb, 15);
            w.r20 = round_sat(-sb*ct, 15);
            w.r21 = round_sat(sb*st, 15);
            w.r22 = cb[15:0];
            w.px  = round_sat(len * w.r00, 15);
            w.py  = round_sat(len * w.r10, 15);
            w.pz  = round_sat(len * w.r20, 15);
            pending_q.push_back(w);
        endfunction

        task check_word(rot_word_t got);
            rot_word_t e;
            if (pending_q.size() == 0) begin
                report_mismatch("result word with nothing pending");
                return;
            end
            e = pending_q.pop_front();
            for (int k = 0; k < 12; k++)
                if (got[k*16 +: 16] !== e[k*16 +: 16])
                    report_mismatch($sformatf("field %0d got %h want %h",
                                              k, got[k*16 +: 16], e[k*16 +: 16]));
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
    logic [InDataW-1:0] s_tdata = '0;
    logic s_tready, m_tvalid;
    logic [OutDataW-1:0] m_tdata;
    kinematics_board board;
    logic written [NJoint*4];
    bit   send_done = 0;
    int   idle_cycles = 0;

    zyz_rotation_and_link_vector u_dut (.*);

    initial forever #4 aclk = ~aclk;

    task automatic send_word(input logic req, input logic [1:0] j, input logic [1:0] sl,
                             input logic [15:0] tv, input logic [15:0] ang,
                             input logic [15:0] len);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, len, ang, tv, sl, j};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_word(req, {4'b0, len, ang, tv, sl, j});
        if (req == ReqLoad) written[j*4+sl] = 1;
    endtask

    task automatic load_joint(input int j);
        for (int k = 0; k < 4; k++)
            send_word(ReqLoad, 2'(j), 2'(k), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_word();
        logic [1:0] j;
        j = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0 || !(written[j*4] && written[j*4+1]
                                           && written[j*4+2] && written[j*4+3]))
            send_word(ReqLoad, j, 2'($urandom_range(0, 3)), 16'($urandom),
                      16'($urandom), 16'($urandom));
        else
            send_word(ReqCompute, j, 2'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
    endtask

    // stimulus
    initial begin
        board = new();
        board.build_wave();
        foreach (written[i]) written[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // full-scale entries on joint 0, extremes on joint 3
        send_word(ReqLoad, 0, 0, 16'h7fff, 0, 0);
        send_word(ReqLoad, 0, 1, 16'h7fff, 0, 0);
        send_word(ReqLoad, 0, 2, 16'h8000, 0, 0);
        send_word(ReqLoad, 0, 3, 16'h8000, 0, 0);
        send_word(ReqLoad, 3, 0, 16'h8000, 0, 0);
        send_word(ReqLoad, 3, 1, 16'h8000, 0, 0);
        send_word(ReqLoad, 3, 2, 16'h7fff, 0, 0);
        send_word(ReqLoad, 3, 3, 16'h0000, 0, 0);
        send_word(ReqCompute, 0, 3, 16'hffff, 16'h0000, 16'h7fff);
        send_word(ReqCompute, 0, 0, 0, 16'h4000, 16'h8000);
        send_word(ReqCompute, 0, 0, 0, 16'h8000, 16'h7fff);
        send_word(ReqCompute, 0, 0, 0, 16'hc000, 16'h8000);
        send_word(ReqCompute, 3, 0, 0, 16'hffff, 16'hffff);
        send_word(ReqCompute, 3, 0, 0, 16'h2000, 16'h0100);
        send_word(ReqCompute, 3, 0, 0, 16'h3fff, 16'h0000);
        send_word(ReqCompute, 0, 0, 0, 16'h7fc1, 16'h8000);
        load_joint(1);
        load_joint(2);
        // hold off until the pipeline drains
        s_tvalid <= 0;
        while (board.pending_q.size() != 0) @(posedge aclk);
        for (int n = 0; n < 530; n++) random_word();
        s_tvalid <= 0;
        send_done = 1;
    end

    // result side
    initial begin
        int wait_n;
        forever begin
            wait_n = $urandom_range(0, 6);
            if (wait_n > 0) begin
                m_tready <= 0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            board.check_word(m_tdata);
        end
    end

    // watchdog and end of run
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (send_done && board.pending_q.size() == 0) begin
                repeat (20) @(posedge aclk);
                if (mismatches == 0 && board.pending_q.size() == 0 && !m_tvalid)
                    $display("simulation ok");
                else
                    $display("simulation failed");
                $finish;
            end
            if (idle_cycles >= 2000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end
endmodule
